>>> rtl/hsl_to_rgb565_converter_core_assert.svh
// assertion macros for the hsl to rgb565 converter
// all macros sample on clock and are off while reset is high
`ifndef HSL_TO_RGB565_CONVERTER_CORE_ASSERT_SVH
`define HSL_TO_RGB565_CONVERTER_CORE_ASSERT_SVH

// same-cycle implication
`define HSLR_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hslr: same-cycle check failed");

// next-cycle implication
`define HSLR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hslr: next-cycle check failed");

`endif

>>> rtl/hslr_pkg.sv
`default_nettype none

package hslr_pkg;

   // fixed point: ONE_VAL stands for 1.0
   localparam int FRAC_BITS  = 8;
   localparam int IN_FRAC    = 8;
   localparam int ONE_VAL    = 1 << FRAC_BITS;
   localparam int FX_W       = FRAC_BITS + 1;
   localparam int SUM_W      = FX_W + 1;

   localparam int HUE_W      = 9;
   localparam int IN_W       = 9;
   localparam int IN_FULL    = 256;
   localparam int HUE_LIMIT  = 360;
   localparam int SECTOR_DEG = 60;
   localparam int F_W        = 6;
   localparam int PROD_W     = FX_W + F_W;

   // divide by 60 as divide by 4 then multiply by a rounded-up reciprocal of 15
   localparam int DIV_PRE    = 2;
   localparam int SUB_DIV    = SECTOR_DEG >> DIV_PRE;
   localparam int DIV_SHIFT  = FRAC_BITS + 8;
   localparam int DIV_RECIP  = ((1 << DIV_SHIFT) + SUB_DIV - 1) / SUB_DIV;
   localparam int RECIP_W    = $clog2(DIV_RECIP + 1);
   localparam int PRE_W      = PROD_W - DIV_PRE;
   localparam int DIVP_W     = PRE_W + RECIP_W;

   // channel scaling
   localparam int RB_SHIFT   = 5;
   localparam int G_SHIFT    = 6;
   localparam int RB_MAX     = 31;
   localparam int G_MAX      = 63;
   localparam int RB_W       = 5;
   localparam int G_W        = 6;
   localparam int PIX_W      = 16;

   typedef enum logic [2:0] {
      SECT_RY = 3'd0,
      SECT_YG = 3'd1,
      SECT_GC = 3'd2,
      SECT_CB = 3'd3,
      SECT_BM = 3'd4,
      SECT_MR = 3'd5
   } sector_type;

   typedef struct packed {
      logic                 hue_error;
      sector_type           sector;
      logic [F_W-1:0]       frac;
      logic [FX_W-1:0]      sat;
      logic [FX_W-1:0]      light;
      logic [FX_W-1:0]      span;
   } decode_type;

   typedef struct packed {
      logic                 hue_error;
      sector_type           sector;
      logic [F_W-1:0]       frac;
      logic [FX_W-1:0]      light;
      logic [FX_W-1:0]      chroma;
   } chroma_type;

   typedef struct packed {
      logic                 hue_error;
      sector_type           sector;
      logic [FX_W-1:0]      chroma;
      logic [FX_W-1:0]      offset;
      logic [PROD_W-1:0]    prod;
   } product_type;

   typedef struct packed {
      logic                 hue_error;
      sector_type           sector;
      logic [FX_W-1:0]      chroma;
      logic [FX_W-1:0]      offset;
      logic [FX_W-1:0]      second;
   } component_type;

   // clamp to full scale, then move from 8 input fraction bits to FRAC_BITS
   function automatic logic [FX_W-1:0] to_fixed(input logic [IN_W-1:0] v);
      logic [IN_W-1:0]           c;
      logic [IN_W+FRAC_BITS-1:0] wide;
      c    = (v > IN_W'(IN_FULL)) ? IN_W'(IN_FULL) : v;
      wide = ((IN_W + FRAC_BITS)'(c) << FRAC_BITS) >> IN_FRAC;
      return wide[FX_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> rtl/hslr_decode.sv
`default_nettype none

module hslr_decode (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire logic [hslr_pkg::HUE_W-1:0] hue_deg,
   input  wire logic [hslr_pkg::IN_W-1:0]  saturation,
   input  wire logic [hslr_pkg::IN_W-1:0]  lightness,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output hslr_pkg::decode_type          out_data
);

   hslr_pkg::decode_type               stage_in;
   hslr_pkg::decode_type               stage_ff;
   logic                               valid_ff;
   hslr_pkg::sector_type               sect;
   logic [hslr_pkg::HUE_W-1:0]         base;
   logic [hslr_pkg::HUE_W-1:0]         diff;
   logic [hslr_pkg::F_W-1:0]           rem;
   logic [hslr_pkg::FX_W-1:0]          light;
   logic [hslr_pkg::FX_W:0]            two_l;
   logic [hslr_pkg::FX_W:0]            dev;

   localparam logic [hslr_pkg::HUE_W-1:0] DEG = hslr_pkg::HUE_W'(hslr_pkg::SECTOR_DEG);
   localparam logic [hslr_pkg::FX_W:0]    ONE = (hslr_pkg::FX_W + 1)'(hslr_pkg::ONE_VAL);

   always_comb begin
      priority if (hue_deg >= hslr_pkg::HUE_W'(5 * DEG)) begin
         sect = hslr_pkg::SECT_MR;
         base = hslr_pkg::HUE_W'(5 * DEG);
      end else if (hue_deg >= hslr_pkg::HUE_W'(4 * DEG)) begin
         sect = hslr_pkg::SECT_BM;
         base = hslr_pkg::HUE_W'(4 * DEG);
      end else if (hue_deg >= hslr_pkg::HUE_W'(3 * DEG)) begin
         sect = hslr_pkg::SECT_CB;
         base = hslr_pkg::HUE_W'(3 * DEG);
      end else if (hue_deg >= hslr_pkg::HUE_W'(2 * DEG)) begin
         sect = hslr_pkg::SECT_GC;
         base = hslr_pkg::HUE_W'(2 * DEG);
      end else if (hue_deg >= DEG) begin
         sect = hslr_pkg::SECT_YG;
         base = DEG;
      end else begin
         sect = hslr_pkg::SECT_RY;
         base = '0;
      end
   end

   assign diff  = hue_deg - base;
   assign rem   = diff[hslr_pkg::F_W-1:0];
   assign light = hslr_pkg::to_fixed(lightness);
   assign two_l = {light, 1'b0};
   assign dev   = (two_l >= ONE) ? (two_l - ONE) : (ONE - two_l);

   always_comb begin
      stage_in.hue_error = (hue_deg >= hslr_pkg::HUE_W'(hslr_pkg::HUE_LIMIT));
      stage_in.sector    = sect;
      // falling slope in odd sectors
      stage_in.frac      = (sect == hslr_pkg::SECT_YG || sect == hslr_pkg::SECT_CB ||
                            sect == hslr_pkg::SECT_MR)
                           ? (hslr_pkg::F_W'(hslr_pkg::SECTOR_DEG) - rem) : rem;
      stage_in.sat       = hslr_pkg::to_fixed(saturation);
      stage_in.light     = light;
      stage_in.span      = hslr_pkg::FX_W'(ONE - dev);
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = stage_ff;

endmodule

`default_nettype wire

>>> rtl/hslr_chroma.sv
`default_nettype none

module hslr_chroma (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire hslr_pkg::decode_type in_data,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output hslr_pkg::product_type     out_data
);

   // stage a: chroma multiply
   hslr_pkg::chroma_type                  mult_in;
   hslr_pkg::chroma_type                  mult_ff;
   logic                                  mult_valid_ff;
   logic                                  mult_ready;
   logic [2*hslr_pkg::FX_W-1:0]           cs_prod;

   // stage b: hue product and offset
   hslr_pkg::product_type                 prod_in;
   hslr_pkg::product_type                 prod_ff;
   logic                                  prod_valid_ff;
   logic [hslr_pkg::FX_W-1:0]             half;

   assign cs_prod = in_data.span * in_data.sat;

   always_comb begin
      mult_in.hue_error = in_data.hue_error;
      mult_in.sector    = in_data.sector;
      mult_in.frac      = in_data.frac;
      mult_in.light     = in_data.light;
      mult_in.chroma    = cs_prod[hslr_pkg::FRAC_BITS +: hslr_pkg::FX_W];
   end

   assign half = mult_ff.chroma >> 1;

   always_comb begin
      prod_in.hue_error = mult_ff.hue_error;
      prod_in.sector    = mult_ff.sector;
      prod_in.chroma    = mult_ff.chroma;
      prod_in.offset    = (mult_ff.light >= half) ? (mult_ff.light - half) : '0;
      prod_in.prod      = hslr_pkg::PROD_W'(mult_ff.chroma * mult_ff.frac);
   end

   assign mult_ready = !prod_valid_ff || out_ready;
   assign in_ready   = !mult_valid_ff || mult_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mult_valid_ff <= 1'b0;
         prod_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            mult_valid_ff <= in_valid;
         end
         if (mult_ready) begin
            prod_valid_ff <= mult_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         mult_ff <= mult_in;
      end
      if (mult_ready && mult_valid_ff) begin
         prod_ff <= prod_in;
      end
   end

   assign out_valid = prod_valid_ff;
   assign out_data  = prod_ff;

endmodule

`default_nettype wire

>>> rtl/hslr_divide.sv
`default_nettype none

module hslr_divide (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire hslr_pkg::product_type in_data,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output hslr_pkg::component_type    out_data
);

   hslr_pkg::component_type               stage_in;
   hslr_pkg::component_type               stage_ff;
   logic                                  valid_ff;
   logic [hslr_pkg::PRE_W-1:0]            pre;
   logic [hslr_pkg::DIVP_W-1:0]           scaled;

   localparam logic [hslr_pkg::RECIP_W-1:0] RECIP = hslr_pkg::RECIP_W'(hslr_pkg::DIV_RECIP);

   // floor(p / 60) = floor(floor(p / 4) / 15), exact over the product range
   assign pre    = hslr_pkg::PRE_W'(in_data.prod >> hslr_pkg::DIV_PRE);
   assign scaled = hslr_pkg::DIVP_W'(pre) * hslr_pkg::DIVP_W'(RECIP);

   always_comb begin
      stage_in.hue_error = in_data.hue_error;
      stage_in.sector    = in_data.sector;
      stage_in.chroma    = in_data.chroma;
      stage_in.offset    = in_data.offset;
      stage_in.second    = scaled[hslr_pkg::DIV_SHIFT +: hslr_pkg::FX_W];
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = stage_ff;

endmodule

`default_nettype wire

>>> rtl/hslr_pack.sv
`default_nettype none

module hslr_pack (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   output logic                         in_ready,
   input  wire hslr_pkg::component_type in_data,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output logic [hslr_pkg::PIX_W-1:0]   out_pixel,
   output logic                         out_error
);

   localparam int SC_W = hslr_pkg::SUM_W + hslr_pkg::G_SHIFT;

   logic [hslr_pkg::FX_W-1:0]   r1;
   logic [hslr_pkg::FX_W-1:0]   g1;
   logic [hslr_pkg::FX_W-1:0]   b1;
   logic [hslr_pkg::RB_W-1:0]   red;
   logic [hslr_pkg::G_W-1:0]    green;
   logic [hslr_pkg::RB_W-1:0]   blue;
   logic [hslr_pkg::PIX_W-1:0]  pixel_in;
   logic [hslr_pkg::PIX_W-1:0]  pixel_ff;
   logic                        error_ff;
   logic                        valid_ff;

   // (component + offset) * 2^shift >> FRAC_BITS, saturated at maxv
   function automatic logic [hslr_pkg::G_W-1:0] scale_chan(
      input logic [hslr_pkg::FX_W-1:0] comp,
      input logic [hslr_pkg::FX_W-1:0] offs,
      input int                        shift,
      input int                        maxv
   );
      logic [hslr_pkg::SUM_W-1:0] sum;
      logic [SC_W-1:0]            q;
      sum = hslr_pkg::SUM_W'(comp) + hslr_pkg::SUM_W'(offs);
      q   = (SC_W'(sum) << shift) >> hslr_pkg::FRAC_BITS;
      return (q > SC_W'(maxv)) ? hslr_pkg::G_W'(maxv) : q[hslr_pkg::G_W-1:0];
   endfunction

   always_comb begin
      unique case (in_data.sector)
         hslr_pkg::SECT_RY: begin
            r1 = in_data.chroma; g1 = in_data.second; b1 = '0;
         end
         hslr_pkg::SECT_YG: begin
            r1 = in_data.second; g1 = in_data.chroma; b1 = '0;
         end
         hslr_pkg::SECT_GC: begin
            r1 = '0; g1 = in_data.chroma; b1 = in_data.second;
         end
         hslr_pkg::SECT_CB: begin
            r1 = '0; g1 = in_data.second; b1 = in_data.chroma;
         end
         hslr_pkg::SECT_BM: begin
            r1 = in_data.second; g1 = '0; b1 = in_data.chroma;
         end
         default: begin
            r1 = in_data.chroma; g1 = '0; b1 = in_data.second;
         end
      endcase
   end

   always_comb begin
      red   = hslr_pkg::RB_W'(scale_chan(r1, in_data.offset, hslr_pkg::RB_SHIFT,
                                         hslr_pkg::RB_MAX));
      green = scale_chan(g1, in_data.offset, hslr_pkg::G_SHIFT, hslr_pkg::G_MAX);
      blue  = hslr_pkg::RB_W'(scale_chan(b1, in_data.offset, hslr_pkg::RB_SHIFT,
                                         hslr_pkg::RB_MAX));
      pixel_in = in_data.hue_error ? '0 : {red, green, blue};
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         pixel_ff <= pixel_in;
         error_ff <= in_data.hue_error;
      end
   end

   assign out_valid = valid_ff;
   assign out_pixel = pixel_ff;
   assign out_error = error_ff;

endmodule

`default_nettype wire

>>> rtl/hsl_to_rgb565_converter_core.sv
// hsl to rgb565 pixel converter. each item on req carries a hue in whole
// degrees and a saturation and a lightness in units of 1/256 (values above
// 256 are taken as 256); each produces exactly one rgb565 item on rsp, in
// order. a hue of 360 or more gives a black pixel with the error flag set.
// the block keeps no state between items. it takes one item every clock
// while rsp is not stalled, through five register stages: sector decode,
// chroma multiply, hue multiply, reciprocal divide by 60, then channel
// scaling into the output register, where the result shows on rsp. each
// stage holds its own valid bit, so a stall on rsp fills the bubbles
// upstream before req sees tready drop.

`default_nettype none

`include "hsl_to_rgb565_converter_core_assert.svh"

module hsl_to_rgb565_converter_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // input items
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // hue_deg[8:0], saturation[17:9], lightness[26:18], zero
   // result items
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,  // pixel[15:0]
   output logic             rsp_tuser   // hue_error[0]
);

   // stage handshakes
   logic                         dec_valid;
   logic                         dec_ready;
   hslr_pkg::decode_type         dec_data;
   logic                         chr_valid;
   logic                         chr_ready;
   hslr_pkg::product_type        chr_data;
   logic                         div_valid;
   logic                         div_ready;
   hslr_pkg::component_type      div_data;

   // the unused top bits of tdata are padding
   hslr_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .hue_deg    (req_tdata[8:0]),
      .saturation (req_tdata[17:9]),
      .lightness  (req_tdata[26:18]),
      .out_valid  (dec_valid),
      .out_ready  (dec_ready),
      .out_data   (dec_data)
   );

   // chroma and the x numerator
   hslr_chroma u_chroma (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_data   (dec_data),
      .out_valid (chr_valid),
      .out_ready (chr_ready),
      .out_data  (chr_data)
   );

   // second component via reciprocal multiply
   hslr_divide u_divide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chr_valid),
      .in_ready  (chr_ready),
      .in_data   (chr_data),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_data  (div_data)
   );

   // channel select, scale, saturate and the output register
   hslr_pack u_pack (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_data   (div_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_pixel (rsp_tdata),
      .out_error (rsp_tuser)
   );

   // out-of-range hue always leaves as black
   `HSLR_ASSERT_NOW(a_error_black, rsp_tvalid && rsp_tuser, rsp_tdata == '0)
   // chroma never exceeds full scale
   `HSLR_ASSERT_NOW(a_chroma_range, chr_valid,
                    chr_data.chroma <= hslr_pkg::FX_W'(hslr_pkg::ONE_VAL))
   // the second component never exceeds chroma for a valid hue
   `HSLR_ASSERT_NOW(a_second_le_chroma, div_valid && !div_data.hue_error,
                    div_data.second <= div_data.chroma)
   // a stalled divide stage keeps its item
   `HSLR_ASSERT_NEXT(a_divide_hold, div_valid && !div_ready, div_valid)

endmodule

`default_nettype wire
